FILE: src/tpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants for the forest path-minimum block.
// ----------------------------------------------------------------------------
package tpm_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LEVELS     = 11;
    localparam int NODE_W     = 11;
    localparam int LVL_W      = 4;
    localparam int WGT_W      = 30;
    localparam int NODE_DEPTH = MAX_NODES + 1;
    localparam int TAB_DEPTH  = NODE_DEPTH << LVL_W;

    localparam logic [WGT_W-1:0] NO_EDGE    = 30'h3f3f3f3f;
    localparam logic [WGT_W-1:0] WEIGHT_MAX = 30'h3f3f3f3e;

    localparam logic MODE_ATTACH = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [WGT_W-1:0]  weight;
    } t_in;

    typedef struct packed {
        logic [WGT_W-1:0] path_min;
        logic             connected;
    } t_out;

    // per-node entry: depth and tree root
    typedef struct packed {
        logic [NODE_W-1:0] depth;
        logic [NODE_W-1:0] root;
    } t_node;

    // lifting entry: 2^j-th ancestor and min weight up to it
    typedef struct packed {
        logic [NODE_W-1:0] anc;
        logic [WGT_W-1:0]  mn;
    } t_tab;

    function automatic logic [WGT_W-1:0] umin(input logic [WGT_W-1:0] a,
                                              input logic [WGT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: src/tree_path_min_binary_lifting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_min_binary_lifting
// Weighted forest with binary-lifting ancestor / path-minimum tables.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken when start is high and busy is low. mode 0 attaches
//   node_a under node_b (0 = new root) with the given edge weight; no result.
//   mode 1 queries the path between node_a and node_b; one result follows,
//   shown on o_result for one cycle with o_strobe high.
//   An attach reads both node entries, then fills each extra lifting level
//   with a read and a write. A query reads both node entries, then runs the
//   depth climb, the meet check, the joint climb and the final step.
//   The lifting table has a single read port: each level that climbs costs
//   one or two dependent reads. Queries with an endpoint out of range answer
//   the next cycle; unattached or split endpoints answer after the node reads.
//   One item at a time; busy stays high until the item is done.
//   After reset the node table is swept to zero, with busy high.
//   The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module tree_path_min_binary_lifting (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  tpm_pkg::t_in i_item,
    output logic         busy,
    output logic         o_strobe,
    output tpm_pkg::t_out o_result
);
    import tpm_pkg::*;

    localparam int NODE_AW = $clog2(NODE_DEPTH);
    localparam int TAB_AW  = $clog2(TAB_DEPTH);

    typedef enum logic [15:0] {
        S_CLR  = 16'b0000_0000_0000_0001,
        S_IDLE = 16'b0000_0000_0000_0010,
        S_RDA  = 16'b0000_0000_0000_0100,
        S_RDB  = 16'b0000_0000_0000_1000,
        S_CHK  = 16'b0000_0000_0001_0000,
        S_LRD  = 16'b0000_0000_0010_0000,
        S_LWR  = 16'b0000_0000_0100_0000,
        S_UP   = 16'b0000_0000_1000_0000,
        S_UPW  = 16'b0000_0001_0000_0000,
        S_MEET = 16'b0000_0010_0000_0000,
        S_L2X  = 16'b0000_0100_0000_0000,
        S_L2Y  = 16'b0000_1000_0000_0000,
        S_L2C  = 16'b0001_0000_0000_0000,
        S_FX   = 16'b0010_0000_0000_0000,
        S_FY   = 16'b0100_0000_0000_0000,
        S_FIN  = 16'b1000_0000_0000_0000
    } t_state;

    t_state            r_state;
    logic [NODE_W-1:0] r_clr;
    logic              r_mode;
    logic [NODE_W-1:0] r_a, r_b, r_x, r_y, r_ax;
    logic [NODE_W-1:0] r_da, r_ra, r_dx, r_dy, r_steps;
    logic [WGT_W-1:0]  r_w, r_m1, r_m2, r_mx;
    logic [LVL_W-1:0]  r_j;
    logic              r_strobe;
    t_out              r_res;

    // memory ports
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr, node_raddr;
    t_node              node_wdata, nd;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
    t_tab               tab_wdata, td;

    // attach decision, valid in S_CHK (nd holds the parent entry)
    logic              att_ok;
    logic [NODE_W-1:0] att_d;
    logic [WGT_W-1:0]  att_w;
    logic [WGT_W-1:0]  lift_mn;
    logic              in_ok_a, in_ok_b;

    assign in_ok_a = (i_item.node_a != '0) && (i_item.node_a <= NODE_W'(MAX_NODES));
    assign in_ok_b = (i_item.node_b <= NODE_W'(MAX_NODES));

    always_comb begin
        att_ok = (r_da == '0) && ((r_b == '0) || (nd.depth != '0)) && (nd.depth != '1);
        att_d  = nd.depth + NODE_W'(1);
        if (r_b == '0) begin
            att_w = '0;
        end else if (r_w > WEIGHT_MAX) begin
            att_w = WEIGHT_MAX;
        end else begin
            att_w = r_w;
        end
        lift_mn = umin(r_m1, td.mn);
    end

    always_comb begin
        node_we    = 1'b0;
        node_waddr = NODE_AW'(r_a);
        node_wdata = '{depth: att_d, root: (r_b == '0) ? r_a : nd.root};
        node_raddr = (r_state == S_RDA) ? NODE_AW'(r_a) : NODE_AW'(r_b);
        tab_we     = 1'b0;
        tab_waddr  = {r_a, LVL_W'(0)};
        tab_wdata  = '{anc: r_b, mn: att_w};
        tab_raddr  = {r_x, r_j};
        unique case (r_state)
            S_CLR: begin
                node_we    = 1'b1;
                node_waddr = NODE_AW'(r_clr);
                node_wdata = '0;
            end
            S_CHK: begin
                node_we = (r_mode == MODE_ATTACH) && att_ok;
                tab_we  = (r_mode == MODE_ATTACH) && att_ok;
            end
            S_LRD: tab_raddr = {r_x, LVL_W'(r_j - LVL_W'(1))};
            S_LWR: begin
                tab_we    = 1'b1;
                tab_waddr = {r_a, r_j};
                tab_wdata = '{anc: td.anc, mn: lift_mn};
            end
            S_L2Y: tab_raddr = {r_y, r_j};
            S_FX:  tab_raddr = {r_x, LVL_W'(0)};
            S_FY:  tab_raddr = {r_y, LVL_W'(0)};
            default: ;
        endcase
    end

    tpm_ram #(.DEPTH(NODE_DEPTH), .WIDTH($bits(t_node))) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (nd)
    );

    tpm_ram #(.DEPTH(TAB_DEPTH), .WIDTH($bits(t_tab))) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (td)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + NODE_W'(1);
                    if (r_clr == NODE_W'(MAX_NODES)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode <= i_item.mode;
                        r_a    <= i_item.node_a;
                        r_b    <= i_item.node_b;
                        r_w    <= i_item.weight;
                        if (i_item.mode == MODE_ATTACH) begin
                            if (in_ok_a && in_ok_b) begin
                                r_state <= S_RDA;
                            end
                        end else if (in_ok_a && in_ok_b && i_item.node_b != '0) begin
                            r_state <= S_RDA;
                        end else begin
                            r_res    <= '0;
                            r_strobe <= 1'b1;
                        end
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_da    <= nd.depth;
                    r_ra    <= nd.root;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_mode == MODE_ATTACH) begin
                        r_x     <= r_b;
                        r_m1    <= att_w;
                        r_dx    <= att_d;
                        r_j     <= LVL_W'(1);
                        r_state <= (att_ok && att_d > NODE_W'(2)) ? S_LRD : S_IDLE;
                    end else if (r_da == '0 || nd.depth == '0 || r_ra != nd.root) begin
                        r_res    <= '0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        if (r_da >= nd.depth) begin
                            r_x <= r_a;
                            r_y <= r_b;
                            r_dy <= nd.depth;
                            r_steps <= r_da - nd.depth;
                        end else begin
                            r_x <= r_b;
                            r_y <= r_a;
                            r_dy <= r_da;
                            r_steps <= nd.depth - r_da;
                        end
                        r_m1    <= NO_EDGE;
                        r_m2    <= NO_EDGE;
                        r_j     <= LVL_W'(LEVELS - 1);
                        r_state <= S_UP;
                    end
                end
                S_LRD: r_state <= S_LWR;
                S_LWR: begin
                    r_x  <= td.anc;
                    r_m1 <= lift_mn;
                    if (r_j != LVL_W'(LEVELS - 1) &&
                        r_dx > (NODE_W'(1) << (r_j + LVL_W'(1)))) begin
                        r_j     <= r_j + LVL_W'(1);
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_UP: begin
                    if (r_steps[r_j]) begin
                        r_state <= S_UPW;
                    end else if (r_j == '0) begin
                        r_state <= S_MEET;
                    end else begin
                        r_j <= r_j - LVL_W'(1);
                    end
                end
                S_UPW: begin
                    r_m1 <= lift_mn;
                    r_x  <= td.anc;
                    if (r_j == '0) begin
                        r_state <= S_MEET;
                    end else begin
                        r_j     <= r_j - LVL_W'(1);
                        r_state <= S_UP;
                    end
                end
                S_MEET: begin
                    r_dx <= r_dy;
                    if (r_x == r_y) begin
                        r_res    <= '{path_min: r_m1, connected: 1'b1};
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_j     <= LVL_W'(LEVELS - 1);
                        r_state <= S_L2X;
                    end
                end
                S_L2X: begin
                    if (r_dx > (NODE_W'(1) << r_j)) begin
                        r_state <= S_L2Y;
                    end else if (r_j == '0) begin
                        r_state <= S_FX;
                    end else begin
                        r_j <= r_j - LVL_W'(1);
                    end
                end
                S_L2Y: begin
                    r_ax    <= td.anc;
                    r_mx    <= td.mn;
                    r_state <= S_L2C;
                end
                S_L2C: begin
                    if (r_ax != td.anc) begin
                        r_m1 <= umin(r_m1, r_mx);
                        r_m2 <= umin(r_m2, td.mn);
                        r_x  <= r_ax;
                        r_y  <= td.anc;
                        r_dx <= r_dx - (NODE_W'(1) << r_j);
                    end
                    if (r_j == '0) begin
                        r_state <= S_FX;
                    end else begin
                        r_j     <= r_j - LVL_W'(1);
                        r_state <= S_L2X;
                    end
                end
                S_FX: r_state <= S_FY;
                S_FY: begin
                    r_m1    <= lift_mn;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res    <= '{path_min: umin(r_m1, umin(r_m2, td.mn)), connected: 1'b1};
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_disc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.connected) |-> (o_result.path_min == '0))
        else $error("disconnected result with nonzero minimum");

    a_lift_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LWR) |-> (r_j != '0 && r_j < LVL_W'(LEVELS)))
        else $error("lifting level out of range");

    a_node0_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (node_we && r_state != S_CLR) |-> (node_waddr != '0))
        else $error("sentinel node written");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) != S_CLR))
        else $error("result during clearing");
`endif

endmodule

FILE: src/tpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
